// ===== sv/bmp24_stream_decoder_core_macros.svh =====
// Assertion helpers for the bitmap stream decoder.
`ifndef BMP24_STREAM_DECODER_CORE_MACROS_SVH
`define BMP24_STREAM_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define BMP24_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BMP24_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bmp24_pkg.sv =====
package bmp24_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam int DIM_W = 13;  // holds 0..MAX_WIDTH
  localparam int LB_W  = 15;  // bytes per line, with room for an out-of-range width
  localparam int IDX_W = 14;  // byte index within a row of a legal image

  localparam logic [7:0] SIG_B     = 8'h42;
  localparam logic [7:0] SIG_M     = 8'h4d;
  localparam logic [15:0] DEPTH_24 = 16'd24;

  // header byte positions
  localparam logic [5:0] POS_SIG1   = 6'd1;
  localparam logic [5:0] POS_OFFSET = 6'd10;
  localparam logic [5:0] POS_WIDTH  = 6'd18;
  localparam logic [5:0] POS_HEIGHT = 6'd22;
  localparam logic [5:0] POS_DEPTH  = 6'd28;
  localparam logic [5:0] POS_LAST   = 6'd53;
  localparam logic [31:0] HDR_BYTES = 32'd54;

  typedef enum logic [2:0] {
    ST_PIXEL      = 3'd0,
    ST_BAD_SIG    = 3'd1,
    ST_BAD_DEPTH  = 3'd2,
    ST_BAD_SIZE   = 3'd3,
    ST_BAD_OFFSET = 3'd4
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] row;
    logic        last_pixel;
  } res_t;

endpackage

// ===== sv/bmp24_stream_decoder_core.sv =====
// Channel   Ports                                    Beat
// input     in_valid, in_stall, in_data_byte,        one file byte
//           in_start_of_file
// output    out_valid, out_stall, out_status, out_red, zero or one result per byte
//           out_green, out_blue, out_column, out_row,
//           out_last_pixel
// One byte per cycle while in_stall is low: a byte's result is registered at the
// edge that accepts the byte, in the output register or, behind it, the skid entry.
// An output register plus a one-entry skid stage decouple the sides; in_stall
// rises only while the skid entry is full.
// Synchronous active-low reset returns to waiting for a start-of-file beat.
module bmp24_stream_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [11:0] out_column,
  output logic [11:0] out_row,
  output logic        out_last_pixel
);
  import bmp24_pkg::*;
  `include "bmp24_stream_decoder_core_macros.svh"

  typedef enum logic [2:0] {
    PH_WAIT, PH_HEADER, PH_SKIP, PH_PIXELS, PH_DONE
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [31:0]        pos_r, pos_nxt;
  logic [31:0]        off_r, off_nxt;
  logic [DIM_W-1:0]   width_r, width_nxt;
  logic               width_hi_r, width_hi_nxt;
  logic [DIM_W-1:0]   height_r, height_nxt;
  logic               height_hi_r, height_hi_nxt;
  logic [15:0]        bpp_r, bpp_nxt;
  logic [LB_W-1:0]    lb_r, lb_nxt;
  logic [LB_W-1:0]    rs_r, rs_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [1:0]         mod3_r, mod3_nxt;
  logic [DIM_W-1:0]   col_r, col_nxt;
  logic [DIM_W-1:0]   rows_r, rows_nxt;
  logic [7:0]         blue_r, blue_nxt;
  logic [7:0]         green_r, green_nxt;

  res_t               out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               skid_r, skid_nxt;
  logic               skid_valid_r, skid_valid_nxt;

  logic               acc;
  logic               out_fire;
  logic               res_v;
  res_t               res;
  logic [LB_W-1:0]    idx_inc;
  logic [LB_W-1:0]    lb_sum;
  logic [LB_W:0]      rs_sum;
  logic [DIM_W-1:0]   row_top;
  logic               size_bad;

  assign in_stall = skid_valid_r;
  assign acc      = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    off_nxt       = off_r;
    width_nxt     = width_r;
    width_hi_nxt  = width_hi_r;
    height_nxt    = height_r;
    height_hi_nxt = height_hi_r;
    bpp_nxt       = bpp_r;
    lb_nxt        = lb_r;
    rs_nxt        = rs_r;
    idx_nxt       = idx_r;
    mod3_nxt      = mod3_r;
    col_nxt       = col_r;
    rows_nxt      = rows_r;
    blue_nxt      = blue_r;
    green_nxt     = green_r;
    res_v         = 1'b0;
    res           = '0;
    res.status    = ST_PIXEL;

    lb_sum   = {1'b0, width_r, 1'b0} + {2'b00, width_r};
    rs_sum   = {1'b0, lb_sum} + {{LB_W{1'b0}}, 1'b1} + {{(LB_W-1){1'b0}}, 2'b10};
    size_bad = width_hi_r || width_r == '0 || width_r > DIM_W'(MAX_WIDTH) ||
               height_hi_r || height_r == '0 || height_r > DIM_W'(MAX_HEIGHT);
    idx_inc  = {1'b0, idx_r} + {{(LB_W-1){1'b0}}, 1'b1};
    row_top  = height_r - {{(DIM_W-1){1'b0}}, 1'b1} - rows_r;

    if (acc) begin
      if (in_start_of_file) begin
        // restart: position, offset, size, depth and pixel counters are cleared here
        phase_nxt     = PH_HEADER;
        pos_nxt       = '0;
        off_nxt       = '0;
        width_nxt     = '0;
        width_hi_nxt  = 1'b0;
        height_nxt    = '0;
        height_hi_nxt = 1'b0;
        bpp_nxt       = '0;
        idx_nxt       = '0;
        mod3_nxt      = '0;
        col_nxt       = '0;
        rows_nxt      = '0;
      end

      case (phase_nxt)
        PH_HEADER: begin
          pos_nxt = pos_nxt + 32'd1;
          if ((pos_nxt == 32'd1 && in_data_byte != SIG_B) ||
              (pos_nxt == {26'd0, POS_SIG1} + 32'd1 && in_data_byte != SIG_M)) begin
            phase_nxt  = PH_DONE;
            res_v      = 1'b1;
            res.status = ST_BAD_SIG;
          end else begin
            case (pos_r[5:0] & {6{!in_start_of_file}})
              POS_OFFSET:          off_nxt[7:0]   = in_data_byte;
              POS_OFFSET + 6'd1:   off_nxt[15:8]  = in_data_byte;
              POS_OFFSET + 6'd2:   off_nxt[23:16] = in_data_byte;
              POS_OFFSET + 6'd3:   off_nxt[31:24] = in_data_byte;
              POS_WIDTH:           width_nxt[7:0] = in_data_byte;
              POS_WIDTH + 6'd1: begin
                width_nxt[12:8] = in_data_byte[4:0];
                width_hi_nxt    = width_hi_r || in_data_byte[7:5] != 3'd0;
              end
              POS_WIDTH + 6'd2,
              POS_WIDTH + 6'd3:    width_hi_nxt = width_hi_r || in_data_byte != 8'd0;
              POS_HEIGHT:          height_nxt[7:0] = in_data_byte;
              POS_HEIGHT + 6'd1: begin
                height_nxt[12:8] = in_data_byte[4:0];
                height_hi_nxt    = height_hi_r || in_data_byte[7:5] != 3'd0;
              end
              POS_HEIGHT + 6'd2,
              POS_HEIGHT + 6'd3:   height_hi_nxt = height_hi_r || in_data_byte != 8'd0;
              POS_DEPTH:           bpp_nxt[7:0]  = in_data_byte;
              POS_DEPTH + 6'd1:    bpp_nxt[15:8] = in_data_byte;
              POS_LAST: begin
                if (!in_start_of_file) begin
                  lb_nxt = lb_sum;
                  rs_nxt = {rs_sum[LB_W-1:2], 2'b00};
                  if (bpp_r != DEPTH_24) begin
                    phase_nxt  = PH_DONE;
                    res_v      = 1'b1;
                    res.status = ST_BAD_DEPTH;
                  end else if (size_bad) begin
                    phase_nxt  = PH_DONE;
                    res_v      = 1'b1;
                    res.status = ST_BAD_SIZE;
                  end else if (off_r < HDR_BYTES || off_r[31]) begin
                    phase_nxt  = PH_DONE;
                    res_v      = 1'b1;
                    res.status = ST_BAD_OFFSET;
                  end else if (off_r == HDR_BYTES) begin
                    phase_nxt = PH_PIXELS;
                  end else begin
                    phase_nxt = PH_SKIP;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        PH_SKIP: begin
          pos_nxt = pos_r + 32'd1;
          if (pos_nxt >= off_r) phase_nxt = PH_PIXELS;
        end
        PH_PIXELS: begin
          if ({1'b0, idx_r} < lb_r) begin
            mod3_nxt = (mod3_r == 2'd2) ? 2'd0 : mod3_r + 2'd1;
            case (mod3_r)
              2'd0: blue_nxt = in_data_byte;
              2'd1: green_nxt = in_data_byte;
              default: begin
                res_v          = 1'b1;
                res.red        = in_data_byte;
                res.green      = green_r;
                res.blue       = blue_r;
                res.column     = col_r[11:0];
                res.row        = row_top[11:0];
                res.last_pixel = (rows_r == height_r - {{(DIM_W-1){1'b0}}, 1'b1}) &&
                                 (col_r == width_r - {{(DIM_W-1){1'b0}}, 1'b1});
                col_nxt        = col_r + {{(DIM_W-1){1'b0}}, 1'b1};
              end
            endcase
          end
          idx_nxt = idx_inc[IDX_W-1:0];
          if (idx_inc >= rs_r) begin
            // end of row, padding included
            idx_nxt  = '0;
            col_nxt  = '0;
            mod3_nxt = '0;
            rows_nxt = rows_r + {{(DIM_W-1){1'b0}}, 1'b1};
            if (rows_nxt >= height_r) phase_nxt = PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  // output register with one skid entry behind it
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_v) begin
      if (!out_valid_r || out_fire) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WAIT;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    pos_r       <= pos_nxt;
    off_r       <= off_nxt;
    width_r     <= width_nxt;
    width_hi_r  <= width_hi_nxt;
    height_r    <= height_nxt;
    height_hi_r <= height_hi_nxt;
    bpp_r       <= bpp_nxt;
    lb_r        <= lb_nxt;
    rs_r        <= rs_nxt;
    idx_r       <= idx_nxt;
    mod3_r      <= mod3_nxt;
    col_r       <= col_nxt;
    rows_r      <= rows_nxt;
    blue_r      <= blue_nxt;
    green_r     <= green_nxt;
    out_r       <= out_nxt;
    skid_r      <= skid_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_r.status;
  assign out_red        = out_r.red;
  assign out_green      = out_r.green;
  assign out_blue       = out_r.blue;
  assign out_column     = out_r.column;
  assign out_row        = out_r.row;
  assign out_last_pixel = out_r.last_pixel;

  `BMP24_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid entry ahead of output")
  `BMP24_ASSERT_NEXT(a_skid_drain, skid_valid_r && !out_stall, out_valid_r && !skid_valid_r, "skid did not drain")
  `BMP24_ASSERT_NOW(a_err_clean, out_valid_r && out_r.status != ST_PIXEL, !out_r.last_pixel && out_r.column == 12'd0 && out_r.red == 8'd0, "error result with pixel payload")
  `BMP24_ASSERT_NOW(a_idx_in_row, phase_r == PH_PIXELS, {1'b0, idx_r} < rs_r, "row byte index past row size")
  `BMP24_ASSERT_NOW(a_col_in_row, phase_r == PH_PIXELS, col_r <= width_r, "column past image width")

endmodule

// ===== tb/bmp24_stream_decoder_core_checker.sv =====
module bmp24_stream_decoder_core_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_file,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic [11:0] out_column,
  input  logic [11:0] out_row,
  input  logic        out_last_pixel,
  output int          fail_count,
  output int          outstanding
);
  import bmp24_pkg::*;

  typedef enum logic [2:0] {
    SEEK_SOF,
    IN_HEADER,
    IN_SKIP,
    IN_PIXELS,
    FINISHED
  } parse_t;

  parse_t      phase;
  logic [31:0] file_pos;
  logic [31:0] pix_start;
  logic [31:0] img_w;
  logic [31:0] img_h;
  logic [31:0] line_pos;
  logic [31:0] col_cnt;
  logic [31:0] rows_seen;
  logic [15:0] depth;
  logic [7:0]  blue_hold;
  logic [7:0]  green_hold;
  res_t        decoded_q[$];
  int          errors = 0;

  assign fail_count = errors;

  task automatic clear_parse();
    phase       = SEEK_SOF;
    file_pos    = '0;
    pix_start   = '0;
    img_w       = '0;
    img_h       = '0;
    line_pos    = '0;
    col_cnt     = '0;
    rows_seen   = '0;
    depth       = '0;
    blue_hold   = '0;
    green_hold  = '0;
  endtask

  task automatic push_result(input status_t st, input logic [7:0] r, g, b,
                             input logic [11:0] col, rw, input logic last);
    res_t entry;
    entry = '{status: st, red: r, green: g, blue: b, column: col,
              row: rw, last_pixel: last};
    decoded_q.insert(decoded_q.size(), entry);
  endtask

  task automatic flag_error(input status_t st);
    phase = FINISHED;
    push_result(st, '0, '0, '0, '0, '0, 1'b0);
  endtask

  function automatic bit size_bad(input logic [31:0] v, input int unsigned lim);
    return v == 0 || v[31] || v > lim;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic sof);
    logic [31:0] p;
    logic [31:0] line_bytes;
    logic [31:0] row_bytes;
    logic [31:0] rw;
    if (sof) begin
      clear_parse();
      phase = IN_HEADER;
    end
    case (phase)
      IN_HEADER: begin
        p = file_pos;
        if ((p == 0 && b != SIG_B) || (p == POS_SIG1 && b != SIG_M)) begin
          flag_error(ST_BAD_SIG);
        end else begin
          // little-endian fields, one byte lane per position
          if (p >= POS_OFFSET && p < POS_OFFSET + 4)
            pix_start |= 32'(b) << (8 * (p - POS_OFFSET));
          if (p >= POS_WIDTH && p < POS_WIDTH + 4)
            img_w |= 32'(b) << (8 * (p - POS_WIDTH));
          if (p >= POS_HEIGHT && p < POS_HEIGHT + 4)
            img_h |= 32'(b) << (8 * (p - POS_HEIGHT));
          if (p >= POS_DEPTH && p < POS_DEPTH + 2)
            depth |= 16'(b) << (8 * (p - POS_DEPTH));
          file_pos = p + 1;
          if (p == POS_LAST) begin
            if (depth != DEPTH_24)
              flag_error(ST_BAD_DEPTH);
            else if (size_bad(img_w, MAX_WIDTH) || size_bad(img_h, MAX_HEIGHT))
              flag_error(ST_BAD_SIZE);
            else if (pix_start < HDR_BYTES || pix_start[31])
              flag_error(ST_BAD_OFFSET);
            else
              phase = (pix_start == HDR_BYTES) ? IN_PIXELS : IN_SKIP;
          end
        end
      end
      IN_SKIP: begin
        file_pos++;
        if (file_pos >= pix_start) phase = IN_PIXELS;
      end
      IN_PIXELS: begin
        line_bytes = img_w * 3;
        row_bytes  = (line_bytes + 3) / 4 * 4;
        if (line_pos < line_bytes) begin
          case (line_pos % 3)
            0: blue_hold = b;
            1: green_hold = b;
            default: begin
              // rows arrive bottom-up
              rw = img_h - 1 - rows_seen;
              push_result(ST_PIXEL, b, green_hold, blue_hold, col_cnt[11:0], rw[11:0],
                          rows_seen == img_h - 1 && col_cnt == img_w - 1);
              col_cnt++;
            end
          endcase
        end
        line_pos++;
        if (line_pos >= row_bytes) begin
          line_pos = '0;
          col_cnt  = '0;
          rows_seen++;
          if (rows_seen >= img_h) phase = FINISHED;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [11:0] want, seen);
    if (seen !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, seen);
    end
  endtask

  task automatic check_result();
    res_t want;
    if (decoded_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: expected none, got status %0d column %0d row %0d",
               $time, out_status, out_column, out_row);
    end else begin
      want = decoded_q.pop_front();
      check_field("status", 12'(want.status), 12'(out_status));
      check_field("red", 12'(want.red), 12'(out_red));
      check_field("green", 12'(want.green), 12'(out_green));
      check_field("blue", 12'(want.blue), 12'(out_blue));
      check_field("column", want.column, out_column);
      check_field("row", want.row, out_row);
      check_field("last_pixel", 12'(want.last_pixel), 12'(out_last_pixel));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parse();
      decoded_q.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) decode_byte(in_data_byte, in_start_of_file);
    end
    outstanding <= decoded_q.size();
  end

endmodule

// ===== tb/bmp24_stream_decoder_core_tb.sv =====
module bmp24_stream_decoder_core_tb;
  import bmp24_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_start_of_file;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [11:0] out_column;
  logic [11:0] out_row;
  logic        out_last_pixel;
  int          fail_count;
  int          outstanding;

  logic [7:0]  img[$];
  int          counted;
  bit          quiet;
  bit          steady;

  bmp24_stream_decoder_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_start_of_file (in_start_of_file),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_column       (out_column),
    .out_row          (out_row),
    .out_last_pixel   (out_last_pixel)
  );

  bmp24_stream_decoder_core_checker u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_start_of_file (in_start_of_file),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_column       (out_column),
    .out_row          (out_row),
    .out_last_pixel   (out_last_pixel),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // mostly short idle runs, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 8))
        @(posedge clk);
      n = quiet ? 0 : idle_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic sof);
    int gap;
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_start_of_file <= sof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = (quiet || steady) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic stream_file(input int n);
    for (int i = 0; i < n; i++) send_beat(img[i], i == 0);
    counted += n;
  endtask

  // beats without a start flag: ignored unless a file is still being parsed
  task automatic send_noise(input int n);
    repeat (n) send_beat(8'($urandom), 1'b0);
  endtask

  task automatic build_file(input logic [31:0] off, w, h, input logic [15:0] bpp,
                            input logic [7:0] sig0, sig1, input bit with_body);
    int row_bytes;
    img.delete();
    repeat (HDR_BYTES) img.insert(img.size(), 8'($urandom));
    img[0]        = sig0;
    img[POS_SIG1] = sig1;
    for (int k = 0; k < 4; k++) begin
      img[POS_OFFSET + k] = off[8*k +: 8];
      img[POS_WIDTH + k]  = w[8*k +: 8];
      img[POS_HEIGHT + k] = h[8*k +: 8];
    end
    img[POS_DEPTH]     = bpp[7:0];
    img[POS_DEPTH + 1] = bpp[15:8];
    if (with_body) begin
      repeat (off - HDR_BYTES) img.insert(img.size(), 8'($urandom));
      row_bytes = (w * 3 + 3) / 4 * 4;
      repeat (row_bytes * h) img.insert(img.size(), 8'($urandom));
    end
  endtask

  task automatic run_image(input logic [31:0] w, h, extra_skip);
    build_file(HDR_BYTES + extra_skip, w, h, DEPTH_24, SIG_B, SIG_M, 1'b1);
    stream_file(img.size());
    send_noise($urandom_range(0, 6));
  endtask

  task automatic bad_header(input logic [31:0] off, w, h, input logic [15:0] bpp);
    build_file(off, w, h, bpp, SIG_B, SIG_M, 1'b0);
    stream_file(img.size());
    send_noise($urandom_range(0, 4));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic random_file();
    int          r;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] off;
    logic [15:0] bpp;
    logic [7:0]  s;
    steady = ($urandom_range(0, 3) == 0);
    r   = $urandom_range(0, 99);
    w   = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 7);
    h   = $urandom_range(1, 5);
    off = HDR_BYTES + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0);
    if (r < 70) begin
      build_file(off, w, h, DEPTH_24, SIG_B, SIG_M, 1'b1);
      if ($urandom_range(0, 4) == 0) begin
        // cut short; the next start of file drops it
        stream_file($urandom_range(1, img.size() - 1));
      end else begin
        stream_file(img.size());
        send_noise($urandom_range(0, 6));
      end
    end else if (r < 75) begin
      if ($urandom_range(0, 1)) begin
        do s = 8'($urandom); while (s == SIG_B);
        build_file(off, w, h, DEPTH_24, s, SIG_M, 1'b0);
        stream_file(1);
      end else begin
        do s = 8'($urandom); while (s == SIG_M);
        build_file(off, w, h, DEPTH_24, SIG_B, s, 1'b0);
        stream_file(2);
      end
      send_noise($urandom_range(0, 4));
    end else begin
      bpp = DEPTH_24;
      if (r < 82) begin
        do bpp = 16'($urandom); while (bpp == DEPTH_24);
        if ($urandom_range(0, 1)) w = '0;  // depth check wins over size
      end else if (r < 92) begin
        case ($urandom_range(0, 5))
          0: w = '0;
          1: h = '0;
          2: w = MAX_WIDTH + 1 + $urandom_range(0, 5000);
          3: h = MAX_HEIGHT + 1 + $urandom_range(0, 5000);
          4: w = 32'h8000_0000 | $urandom;
          default: h = 32'h8000_0000 | $urandom;
        endcase
        if ($urandom_range(0, 2) == 0) off = $urandom_range(0, 53);  // size check wins
      end else begin
        off = $urandom_range(0, 1) ? $urandom_range(0, 53) : (32'h8000_0000 | $urandom);
      end
      bad_header(off, w, h, bpp);
    end
    if ($urandom_range(0, 19) == 0) send_noise($urandom_range(1, 5));
    if ($urandom_range(0, 7) == 0) wait_drained();
  endtask

  initial begin
    int cnt;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_data_byte     <= '0;
    in_start_of_file <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // stray bytes before any file
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    run_image(1, 1, 0);
    run_image(3, 2, 6);
    // restart in the middle of the pixel rows
    build_file(HDR_BYTES, 5, 3, DEPTH_24, SIG_B, SIG_M, 1'b1);
    stream_file(img.size() - 5);
    run_image(4, 2, 1);
    build_file(HDR_BYTES, 1, 1, DEPTH_24, 8'h00, SIG_M, 1'b0);
    stream_file(3);
    build_file(HDR_BYTES, 1, 1, DEPTH_24, SIG_B, 8'hFF, 1'b0);
    stream_file(3);
    bad_header(HDR_BYTES, 1, 1, 16'd32);
    bad_header(HDR_BYTES, 1, 1, DEPTH_24 + 16'h0100);
    bad_header(HDR_BYTES, 0, 1, DEPTH_24);
    bad_header(HDR_BYTES, 1, MAX_HEIGHT + 1, DEPTH_24);
    bad_header(HDR_BYTES, 1, 32'hFFFF_FFFF, DEPTH_24);
    bad_header(HDR_BYTES - 1, 1, 1, DEPTH_24);
    bad_header(32'h8000_0036, 1, 1, DEPTH_24);
    wait_drained();

    // largest legal sizes: header accepted and the first pixels checked, then the
    // next file cuts them off
    quiet = 1'b1;
    build_file(HDR_BYTES, MAX_WIDTH, 1, DEPTH_24, SIG_B, SIG_M, 1'b1);
    stream_file(HDR_BYTES + 9);
    build_file(HDR_BYTES + 3, 1, MAX_HEIGHT, DEPTH_24, SIG_B, SIG_M, 1'b1);
    stream_file(HDR_BYTES + 3 + 8);
    quiet = 1'b0;

    while (counted < 950) random_file();
    steady = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    cnt = 0;
    while (outstanding != 0 && cnt < 50000) begin
      @(posedge clk);
      cnt++;
    end
    repeat (20) @(posedge clk);
    if (outstanding != 0) $display("%0t: %0d expected results never arrived", $time, outstanding);
    if (fail_count == 0 && outstanding == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
